// File: hw/rtl/i2cms_pkg.sv
// Package for the I2C master byte sequencer: word types, command codes and step counts.
package i2cms_pkg;

  localparam int unsigned BitsPerByte  = 8;
  localparam int unsigned DataBitSteps = 3 * BitsPerByte;
  localparam int unsigned StepW        = 5;
  localparam int unsigned TimerW       = 16;
  localparam logic [TimerW-1:0] PeriodReset = 16'd240;

  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_STOP   = 3'd1,
    KIND_RSTART = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_t;

  typedef struct packed {
    logic [TimerW-1:0] timer;
    logic [StepW-1:0]  step;
    kind_e             kind;
    logic              busy;
    logic [7:0]        shift;
    logic              ack;
    logic              scl;
    logic              sda;
    logic              drv;
    logic [7:0]        rd;
  } seq_t;

  function automatic logic [StepW-1:0] step_count(kind_e k);
    logic [StepW-1:0] n;
    unique case (k)
      KIND_START:  n = StepW'(4);
      KIND_STOP:   n = StepW'(3);
      KIND_RSTART: n = StepW'(8);
      default:     n = StepW'(DataBitSteps + 3);
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/i2cms_tick.sv
// Per-tick next-state and result logic of the I2C master byte sequencer.
module i2cms_tick (
  input  i2cms_pkg::seq_t             cur_i,
  input  i2cms_pkg::in_t              word_i,
  input  logic [i2cms_pkg::TimerW-1:0] period_i,
  output i2cms_pkg::seq_t             nxt_o,
  output i2cms_pkg::out_t             res_o
);

  localparam int unsigned StepW = i2cms_pkg::StepW;

  logic                          load;
  logic                          run_step;
  logic                          finish;
  logic [StepW-1:0]              step_n;
  logic [StepW-1:0]              s;
  i2cms_pkg::kind_e              k;
  logic [8:0]                    prod;
  logic [3:0]                    quot;
  logic [1:0]                    rem;
  logic [StepW-1:0]              s_start;
  logic [i2cms_pkg::TimerW-1:0]  per;
  i2cms_pkg::seq_t               base;
  i2cms_pkg::seq_t               nxt;

  assign per  = (period_i == '0) ? i2cms_pkg::TimerW'(1) : period_i;
  assign load = !cur_i.busy && word_i.cmd_valid && (word_i.kind <= i2cms_pkg::KIND_READ);
  assign step_n = cur_i.step + StepW'(1);
  assign finish = cur_i.busy && (cur_i.timer <= i2cms_pkg::TimerW'(1)) &&
                  (step_n >= i2cms_pkg::step_count(cur_i.kind));
  assign run_step = load || (cur_i.busy && (cur_i.timer <= i2cms_pkg::TimerW'(1)) && !finish);

  // step mod 3 via reciprocal, exact for 5-bit steps
  assign prod = 9'(s) * 9'd11;
  assign quot = prod[8:5];
  assign rem  = 2'(s - StepW'(quot * 4'd3));
  assign s_start = (k == i2cms_pkg::KIND_RSTART) ? s - StepW'(4) : s;

  always_comb begin
    base = cur_i;
    if (load) begin
      base.kind = i2cms_pkg::kind_e'(word_i.kind);
      base.busy = 1'b1;
      base.step = '0;
      if (word_i.kind == i2cms_pkg::KIND_WRITE) base.shift = word_i.write_data;
      if (word_i.kind == i2cms_pkg::KIND_READ) begin
        base.shift = '0;
        base.ack   = word_i.send_ack;
      end
    end else if (cur_i.busy && !run_step && !finish) begin
      base.timer = cur_i.timer - i2cms_pkg::TimerW'(1);
    end else if (run_step) begin
      base.step = step_n;
    end
    s = base.step;
    k = base.kind;
  end

  always_comb begin
    nxt = base;
    if (finish) begin
      if (cur_i.kind == i2cms_pkg::KIND_READ) nxt.rd = cur_i.shift;
      nxt.busy  = 1'b0;
      nxt.timer = '0;
      nxt.step  = '0;
    end else if (run_step) begin
      nxt.timer = per;
      unique case (k)
        i2cms_pkg::KIND_START, i2cms_pkg::KIND_RSTART: begin
          if (k == i2cms_pkg::KIND_RSTART && s < StepW'(3)) begin
            unique case (s)
              StepW'(0): begin nxt.drv = 1'b1; nxt.sda = 1'b0; end
              StepW'(1): nxt.scl = 1'b1;
              default:   nxt.sda = 1'b1;
            endcase
          end else if (k == i2cms_pkg::KIND_START || s > StepW'(3)) begin
            unique case (s_start)
              StepW'(0): begin nxt.drv = 1'b1; nxt.sda = 1'b1; end
              StepW'(1): nxt.scl = 1'b1;
              StepW'(2): nxt.sda = 1'b0;
              default:   nxt.scl = 1'b0;
            endcase
          end
        end
        i2cms_pkg::KIND_STOP: begin
          unique case (s)
            StepW'(0): begin nxt.drv = 1'b1; nxt.sda = 1'b0; end
            StepW'(1): nxt.scl = 1'b1;
            default:   nxt.sda = 1'b1;
          endcase
        end
        i2cms_pkg::KIND_WRITE: begin
          if (s < StepW'(i2cms_pkg::DataBitSteps)) begin
            if (rem == 2'd0) begin
              nxt.sda   = base.shift[7];
              nxt.shift = {base.shift[6:0], 1'b0};
            end else begin
              nxt.scl = (rem == 2'd1);
            end
          end else if (s == StepW'(i2cms_pkg::DataBitSteps)) begin
            nxt.drv = 1'b0;
          end else if (s == StepW'(i2cms_pkg::DataBitSteps + 1)) begin
            nxt.scl = 1'b1;
          end else begin
            nxt.scl = 1'b0;
            nxt.drv = 1'b1;
          end
        end
        default: begin
          if (s == '0) nxt.drv = 1'b0;
          if (s < StepW'(i2cms_pkg::DataBitSteps)) begin
            if (rem == 2'd0) begin
              nxt.shift = {base.shift[6:0], 1'b0};
            end else if (rem == 2'd1) begin
              nxt.scl = 1'b1;
            end else begin
              nxt.shift = {base.shift[7:1], word_i.sda_in};
              nxt.scl   = 1'b0;
            end
          end else if (s == StepW'(i2cms_pkg::DataBitSteps)) begin
            nxt.drv = 1'b1;
            nxt.sda = !base.ack;
          end else if (s == StepW'(i2cms_pkg::DataBitSteps + 1)) begin
            nxt.scl = 1'b1;
          end else begin
            nxt.scl = 1'b0;
            nxt.sda = 1'b1;
          end
        end
      endcase
    end
  end

  assign nxt_o = nxt;

  always_comb begin
    res_o.scl_level = nxt.scl;
    res_o.sda_level = nxt.sda;
    res_o.sda_drive = nxt.drv;
    res_o.ready_res = !nxt.busy;
    res_o.done_res  = finish;
    res_o.read_data = nxt.rd;
  end

endmodule

// File: hw/rtl/i2c_master_byte_sequencer_core.sv
// Top level of the I2C master byte sequencer: state, config and result registers.
//
// Input channel (in_valid_i/in_ready_o/in_i): one word is one bus tick. It may
// carry a command (start, stop, repeated start, write byte, read byte) and the
// sampled SDA level. Commands are taken only while the sequencer is idle.
// Output channel (out_valid_o/out_ready_i/out_o): one word per input word with
// the SCL/SDA line levels, SDA drive enable, ready, a done pulse and read byte.
// The result of a word shows in the cycle after it is accepted. A word can be
// taken every cycle while the receiver takes results; the tick logic sits
// between the state registers and the result register, which is the only stage.
// A stalled result holds in the output register; a new word is still taken in
// the cycle the receiver takes the waiting one.
// cfg_we_i/cfg_wdata_i write the half period in ticks (0 acts as 1).
// Reset leaves the bus idle high and driven, half period 240, output empty.
module i2c_master_byte_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  i2cms_pkg::in_t                in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output i2cms_pkg::out_t               out_o,
  input  logic                          cfg_we_i,
  input  logic [i2cms_pkg::TimerW-1:0]  cfg_wdata_i
);

  i2cms_pkg::seq_t              seq_q, seq_d;
  i2cms_pkg::out_t              out_q, out_d;
  logic                         out_valid_q;
  logic [i2cms_pkg::TimerW-1:0] period_q;
  logic                         accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  i2cms_tick u_tick (
    .cur_i    (seq_q),
    .word_i   (in_i),
    .period_i (period_q),
    .nxt_o    (seq_d),
    .res_o    (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '{timer: '0, step: '0, kind: i2cms_pkg::KIND_START, busy: 1'b0,
                       shift: '0, ack: 1'b0, scl: 1'b1, sda: 1'b1, drv: 1'b1, rd: '0};
      out_valid_q <= 1'b0;
      period_q    <= i2cms_pkg::PeriodReset;
    end else begin
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (accept) begin
        seq_q       <= seq_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: hw/rtl/i2cms_checker.sv
// Port-level assertions for the I2C master byte sequencer, bound to the top level.
module i2cms_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input i2cms_pkg::out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result word changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output space");

  a_one_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word gave no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.done_res |-> out_o.ready_res)
    else $error("done pulse while busy");

  a_idle_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.ready_res |-> out_o.sda_drive)
    else $error("SDA released while idle");

endmodule

bind i2c_master_byte_sequencer_core i2cms_checker u_i2cms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
